/* hdl/smg_pkg.sv */
package smg_pkg;

  localparam int unsigned SMG_SCALE_DEF = 1;
  localparam int unsigned SMG_SCALE_MAX = 255;

  localparam int unsigned EDGE_LOG2_W   = 5;
  localparam int unsigned CFG_DATA_W    = 5;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned COORD_W       = 16;
  localparam int unsigned CNT_W         = 8;

  localparam logic [EDGE_LOG2_W-1:0] EDGE_LOG2_RST = 5'd17;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LOG2 = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PWR_EN    = 1'b1;

  // action codes
  localparam logic [2:0] ACT_SUB_ON   = 3'd0;
  localparam logic [2:0] ACT_SUB_OFF  = 3'd1;
  localparam logic [2:0] ACT_SENT     = 3'd2;
  localparam logic [2:0] ACT_PWR_DOWN = 3'd3;
  localparam logic [2:0] ACT_WAKE_UP  = 3'd4;
  localparam logic [2:0] ACT_START    = 3'd5;
  localparam logic [2:0] ACT_STOP     = 3'd6;

  typedef struct packed {
    logic [2:0]  action;
    logic        is_mouse_report;
    logic [31:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] delta_x;
    logic signed [COORD_W-1:0] delta_y;
  } out_item_t;

  // octagon vertices, x then y, in units of scale
  function automatic logic signed [COORD_W-1:0] vert_x(input logic [2:0] idx,
                                                       input int unsigned scale);
    int v;
    case (idx)
      3'd0:    v = -50;
      3'd1:    v = -35;
      3'd2:    v = 0;
      3'd3:    v = 35;
      3'd4:    v = 50;
      3'd5:    v = 35;
      3'd6:    v = 0;
      default: v = -35;
    endcase
    return COORD_W'(v * int'(scale));
  endfunction

  function automatic logic signed [COORD_W-1:0] vert_y(input logic [2:0] idx,
                                                       input int unsigned scale);
    int v;
    case (idx)
      3'd0:    v = 0;
      3'd1:    v = -35;
      3'd2:    v = -50;
      3'd3:    v = -35;
      3'd4:    v = 0;
      3'd5:    v = 35;
      3'd6:    v = 50;
      default: v = 35;
    endcase
    return COORD_W'(v * int'(scale));
  endfunction

endpackage

/* hdl/smg_lerp.sv */
module smg_lerp #(
  parameter int unsigned SCALE = smg_pkg::SMG_SCALE_DEF,
  parameter bit          AXIS_Y = 1'b0
) (
  input  logic [smg_pkg::EDGE_LOG2_W-1:0]    edge_log2,
  input  logic [31:0]                        t,
  output logic signed [smg_pkg::COORD_W-1:0] pos
);
  import smg_pkg::*;

  localparam int unsigned PROD_W = COORD_W + 32;

  logic [31:0]                 seg;
  logic [2:0]                  v1;
  logic [2:0]                  v2;
  logic signed [COORD_W-1:0]   p1;
  logic signed [COORD_W-1:0]   p2;
  logic signed [COORD_W-1:0]   diff;
  logic [32:0]                 mask;
  logic [30:0]                 frac;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    biased;
  logic signed [PROD_W-1:0]    quot;

  always_comb begin
    seg  = t >> edge_log2;
    v1   = seg[2:0];
    v2   = v1 + 3'd1;
    p1   = AXIS_Y ? vert_y(v1, SCALE) : vert_x(v1, SCALE);
    p2   = AXIS_Y ? vert_y(v2, SCALE) : vert_x(v2, SCALE);
    diff = p2 - p1;
    mask = (33'd1 << edge_log2) - 33'd1;
    frac = t[30:0] & mask[30:0];
    prod = PROD_W'(diff) * $signed({{(PROD_W-31){1'b0}}, frac});
    // round toward zero: bias negative products before the arithmetic shift
    biased = prod + (prod[PROD_W-1] ? $signed({{(PROD_W-31){1'b0}}, mask[30:0]})
                                    : '0);
    quot = biased >>> edge_log2;
    pos  = p1 + quot[COORD_W-1:0];
  end

endmodule

/* hdl/simulated_motion_generator.sv */
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   in_item   (action, is_mouse_report, timestamp_us)
// out_     output     out_valid / out_ready out_item  (delta_x, delta_y)
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One item per cycle while the output is not stalled: an item is held in the input
// register, then its mode update and interpolation (one 16x31 multiply and a shift)
// land in the state and result registers. out_valid comes from the result register,
// behind the input register, and rises only for an item that produces a sample.
// Input stalls only while a result waits in the output register and the
// input register is full. Synchronous active-low reset; no clearing pass.
module simulated_motion_generator #(
  parameter int unsigned SCALE = smg_pkg::SMG_SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  smg_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output smg_pkg::out_item_t                  out_item,
  input  logic                                cfg_we,
  input  logic [smg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smg_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import smg_pkg::*;

  typedef enum logic [2:0] {
    MODE_DISC      = 3'd0,
    MODE_IDLE      = 3'd1,
    MODE_FETCH     = 3'd2,
    MODE_SUSP      = 3'd3,
    MODE_SUSP_DISC = 3'd4
  } mode_t;

  mode_t                      mode_r, mode_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       gen_r, gen_nxt;
  logic signed [COORD_W-1:0]  pos_x_r, pos_x_nxt;
  logic signed [COORD_W-1:0]  pos_y_r, pos_y_nxt;
  logic [EDGE_LOG2_W-1:0]     edge_log2_r;
  logic                       pwr_en_r;
  logic                       s0_valid_r;
  in_item_t                   s0_item_r;
  logic                       out_valid_r;
  out_item_t                  out_item_r, out_item_nxt;
  logic                       advance;
  logic                       emit;
  logic signed [COORD_W-1:0]  lerp_x;
  logic signed [COORD_W-1:0]  lerp_y;

  assign advance   = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s0_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  smg_lerp #(.SCALE(SCALE), .AXIS_Y(1'b0)) u_lerp_x (
    .edge_log2 (edge_log2_r),
    .t         (s0_item_r.timestamp_us),
    .pos       (lerp_x)
  );

  smg_lerp #(.SCALE(SCALE), .AXIS_Y(1'b1)) u_lerp_y (
    .edge_log2 (edge_log2_r),
    .t         (s0_item_r.timestamp_us),
    .pos       (lerp_y)
  );

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    gen_nxt   = gen_r;
    emit      = 1'b0;
    case (s0_item_r.action)
      ACT_SUB_ON: begin
        if (s0_item_r.is_mouse_report && count_r != '1) begin
          count_nxt = count_r + CNT_W'(1);
          if (count_r == '0) begin
            if (mode_r == MODE_DISC) begin
              mode_nxt = gen_r ? MODE_FETCH : MODE_IDLE;
              emit     = gen_r;
            end else if (mode_r == MODE_SUSP_DISC) begin
              mode_nxt = MODE_SUSP;
            end
          end
        end
      end
      ACT_SUB_OFF: begin
        if (s0_item_r.is_mouse_report && count_r != '0) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            if (mode_r == MODE_FETCH || mode_r == MODE_IDLE) begin
              mode_nxt = MODE_DISC;
            end else if (mode_r == MODE_SUSP) begin
              mode_nxt = MODE_SUSP_DISC;
            end
          end
        end
      end
      ACT_SENT: begin
        if (s0_item_r.is_mouse_report && mode_r == MODE_FETCH) begin
          emit = 1'b1;
          if (!gen_r) begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      ACT_PWR_DOWN: begin
        if (pwr_en_r) begin
          if (mode_r == MODE_DISC) begin
            mode_nxt = MODE_SUSP_DISC;
          end else if (mode_r == MODE_IDLE || mode_r == MODE_FETCH) begin
            mode_nxt = MODE_SUSP;
          end
        end
      end
      ACT_WAKE_UP: begin
        if (pwr_en_r) begin
          if (mode_r == MODE_SUSP_DISC) begin
            mode_nxt = MODE_DISC;
          end else if (mode_r == MODE_SUSP) begin
            mode_nxt = gen_r ? MODE_FETCH : MODE_IDLE;
            emit     = gen_r;
          end
        end
      end
      ACT_START: begin
        if (!gen_r) begin
          gen_nxt = 1'b1;
          if (mode_r == MODE_IDLE) begin
            mode_nxt = MODE_FETCH;
            emit     = 1'b1;
          end
        end
      end
      ACT_STOP: begin
        gen_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    // hold the position while stopped so the sample reads zero
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (emit && gen_nxt) begin
      pos_x_nxt = lerp_x;
      pos_y_nxt = lerp_y;
    end
    out_item_nxt.delta_x = pos_x_nxt - pos_x_r;
    out_item_nxt.delta_y = pos_y_nxt - pos_y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_DISC;
      count_r     <= '0;
      gen_r       <= 1'b1;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      edge_log2_r <= EDGE_LOG2_RST;
      pwr_en_r    <= 1'b1;
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EDGE_LOG2: edge_log2_r <= cfg_wdata[EDGE_LOG2_W-1:0];
          CFG_PWR_EN:    pwr_en_r    <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (in_ready) begin
        s0_valid_r <= in_valid;
      end
      if (advance) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
        gen_r   <= gen_nxt;
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
      if (advance) begin
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_item_r <= in_item;
    end
    if (advance && emit) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

/* hdl/smg_checker.sv */
module smg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input smg_pkg::out_item_t out_item
);
  import smg_pkg::*;

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // input stalls only behind a result that waits
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a new result must trace back to an item accepted through the input register
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an accepted item");

endmodule

bind simulated_motion_generator smg_checker u_smg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
